### rtl/pvfs_pkg.sv
// Package: state codes, command and register codes, constants for the velocity step core.
`default_nettype none
package pvfs_pkg;

  localparam logic [1:0] CMD_TICK   = 2'd0;
  localparam logic [1:0] CMD_SET    = 2'd1;
  localparam logic [1:0] CMD_FORCE  = 2'd2;
  localparam logic [1:0] CMD_REPORT = 2'd3;

  localparam logic [1:0] REG_MAX_SPEED = 2'd0;
  localparam logic [1:0] REG_BODY_MASS = 2'd1;
  localparam logic [1:0] REG_FRICTION  = 2'd2;

  localparam logic [30:0] MAX_SPEED_RST = 31'd327680;
  localparam logic [30:0] BODY_MASS_RST = 31'd65536;
  localparam logic [30:0] FRICTION_RST  = 31'd32768;

  // 0.1 in Q16.16
  localparam logic [31:0] SLOW_Q16 = 32'd6554;

  localparam int DIV_STEPS = 48;

  typedef enum logic [4:0] {
    ST_IDLE, ST_THR, ST_SQ0, ST_SQ1, ST_CHK, ST_SQRT, ST_UNY, ST_UEND,
    ST_FMX, ST_FSX, ST_FMY, ST_FSY, ST_FRC1, ST_FEND, ST_ADD,
    ST_LMX, ST_LSX, ST_LSY, ST_MOVE, ST_OUT, ST_DIV
  } state_t;

  typedef enum logic [1:0] {CHK_FRIC, CHK_LIM, CHK_SLOW, CHK_HEAD} chk_t;
  typedef enum logic [1:0] {CTX_FRIC, CTX_LIM, CTX_HEAD} ctx_t;

endpackage
`default_nettype wire

### rtl/pvfs_in_if.sv
// Interface: input command channel.
`default_nettype none
interface pvfs_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         command;
  logic signed [31:0] value_x;
  logic signed [31:0] value_y;
  modport source(output valid, command, value_x, value_y, input ready);
  modport sink(input valid, command, value_x, value_y, output ready);
endinterface
`default_nettype wire

### rtl/pvfs_out_if.sv
// Interface: result state channel.
`default_nettype none
interface pvfs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] vel_x;
  logic signed [31:0] vel_y;
  logic signed [15:0] heading_x;
  logic signed [15:0] heading_y;
  modport source(output valid, pos_x, pos_y, vel_x, vel_y, heading_x, heading_y, input ready);
  modport sink(input valid, pos_x, pos_y, vel_x, vel_y, heading_x, heading_y, output ready);
endinterface
`default_nettype wire

### rtl/pvfs_cfg_if.sv
// Interface: configuration register write channel.
`default_nettype none
interface pvfs_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [30:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

### rtl/planar_velocity_friction_step_core.sv
// Top level: 2D body velocity/position/heading step core with friction and speed limit.
// Usage:
//  in_ch  : one beat per command (0 tick, 1 set velocity, 2 add force, 3 report).
//  out_ch : one beat per command with position, velocity and heading after it.
//  cfg_ch : register writes (0 max_speed, 1 body_mass, 2 friction_coeff), always
//           ready; write only while the core is idle.
// Timing: one command at a time. Each speed check uses the shared 32x32
//  multiplier, each unit vector a square root plus two divides on the shared
//  restoring divider; friction and force add two more divides.
//  in_ch.ready is high only in idle.
// Stall: the result sits in an output register; the core returns to idle and
//  accepts the next command while it waits. A later result waits in the final
//  state until the register is free.
// Reset (rst_n low, synchronous): state zeroed, registers to defaults, no beat
//  pending.
`default_nettype none
module planar_velocity_friction_step_core (
  input  logic         clk,
  input  logic         rst_n,
  pvfs_in_if.sink      in_ch,
  pvfs_out_if.source   out_ch,
  pvfs_cfg_if.sink     cfg_ch
);
  import pvfs_pkg::*;

  function automatic logic [31:0] abs32(input logic [31:0] v);
    abs32 = v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [15:0] abs16(input logic [15:0] v);
    abs16 = v[15] ? (~v + 16'd1) : v;
  endfunction

  function automatic logic [31:0] sat_add(input logic [31:0] v, input logic [48:0] d);
    logic signed [49:0] s;
    s = $signed({{18{v[31]}}, v}) + $signed({d[48], d});
    if (s > 50'sd2147483647)       sat_add = 32'h7fff_ffff;
    else if (s < -50'sd2147483648) sat_add = 32'h8000_0000;
    else                           sat_add = s[31:0];
  endfunction

  // state and config
  state_t       state_r, state_nxt, dret_r, dret_nxt;
  chk_t         chk_r, chk_nxt;
  ctx_t         ctx_r, ctx_nxt;
  logic [1:0]   cmd_r, cmd_nxt;
  logic [31:0]  vin_y_r, vin_y_nxt;
  logic [31:0]  vel_x_r, vel_x_nxt, vel_y_r, vel_y_nxt;
  logic [31:0]  pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt;
  logic signed [15:0] dir_x_r, dir_x_nxt, dir_y_r, dir_y_nxt;
  logic [15:0]  ux_r, ux_nxt, uy_r, uy_nxt;
  logic [48:0]  dx_r, dx_nxt;
  logic [63:0]  sq_r, sq_nxt, thr_r, thr_nxt;
  logic [63:0]  s_r, s_nxt, rt_r, rt_nxt, bit_r, bit_nxt;
  logic [63:0]  prod_r, prod_nxt;
  logic         psgn_r, psgn_nxt;
  logic [47:0]  dvd_r, dvd_nxt;
  logic [31:0]  dvs_r, dvs_nxt, rem_r, rem_nxt;
  logic [5:0]   cnt_r, cnt_nxt;
  logic         dneg_r, dneg_nxt;
  logic [30:0]  ms_r, mass_r, fric_r;
  logic         out_valid_r, out_valid_nxt;
  logic [31:0]  o_px_r, o_py_r, o_vx_r, o_vy_r;
  logic [15:0]  o_hx_r, o_hy_r;
  logic         out_load;

  // shared units
  logic [31:0]  mul_a, mul_b;
  logic [63:0]  mul_p;
  logic         div_go, div_neg, sqrt_go;
  logic [47:0]  div_dvd;
  logic [31:0]  div_dvs;
  state_t       div_ret;
  logic [32:0]  rem_sh;
  logic         rem_ge;
  logic [48:0]  q_cur;
  logic [31:0]  mass1, thr_sel, lim_m;
  logic [63:0]  rt_bit;

  assign mul_p  = mul_a * mul_b;
  assign rem_sh = {rem_r, dvd_r[47]};
  assign rem_ge = rem_sh >= {1'b0, dvs_r};
  assign q_cur  = dneg_r ? (~{1'b0, dvd_r} + 49'd1) : {1'b0, dvd_r};
  assign mass1  = (mass_r == 31'd0) ? 32'd1 : {1'b0, mass_r};
  assign rt_bit = rt_r + bit_r;
  assign lim_m  = prod_r[45:14];

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_valid_r;
  assign out_ch.pos_x = o_px_r;
  assign out_ch.pos_y = o_py_r;
  assign out_ch.vel_x = o_vx_r;
  assign out_ch.vel_y = o_vy_r;
  assign out_ch.heading_x = o_hx_r;
  assign out_ch.heading_y = o_hy_r;

  always_comb begin
    unique case (chk_r)
      CHK_FRIC: thr_sel = {1'b0, fric_r};
      CHK_LIM:  thr_sel = {1'b0, ms_r};
      default:  thr_sel = SLOW_Q16;
    endcase
  end

  always_comb begin
    state_nxt = state_r;  dret_nxt = dret_r;  chk_nxt = chk_r;  ctx_nxt = ctx_r;
    cmd_nxt = cmd_r;  vin_y_nxt = vin_y_r;
    vel_x_nxt = vel_x_r;  vel_y_nxt = vel_y_r;  pos_x_nxt = pos_x_r;  pos_y_nxt = pos_y_r;
    dir_x_nxt = dir_x_r;  dir_y_nxt = dir_y_r;  ux_nxt = ux_r;  uy_nxt = uy_r;
    dx_nxt = dx_r;  sq_nxt = sq_r;  thr_nxt = thr_r;
    s_nxt = s_r;  rt_nxt = rt_r;  bit_nxt = bit_r;  prod_nxt = prod_r;  psgn_nxt = psgn_r;
    dvd_nxt = dvd_r;  dvs_nxt = dvs_r;  rem_nxt = rem_r;  cnt_nxt = cnt_r;  dneg_nxt = dneg_r;
    mul_a = 32'd0;  mul_b = 32'd0;
    div_go = 1'b0;  div_neg = 1'b0;  div_dvd = 48'd0;  div_dvs = 32'd1;  div_ret = ST_IDLE;
    sqrt_go = 1'b0;  out_load = 1'b0;
    out_valid_nxt = out_valid_r && !out_ch.ready;

    unique case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt   = in_ch.command;
          vin_y_nxt = in_ch.value_y;
          unique case (in_ch.command)
            CMD_TICK: begin
              chk_nxt = CHK_FRIC;  state_nxt = ST_THR;
            end
            CMD_SET: begin
              vel_x_nxt = in_ch.value_x;  vel_y_nxt = in_ch.value_y;
              chk_nxt = CHK_LIM;  state_nxt = ST_THR;
            end
            CMD_FORCE: begin
              div_go = 1'b1;  div_dvd = {abs32(in_ch.value_x), 16'd0};
              div_dvs = mass1;  div_neg = in_ch.value_x[31];  div_ret = ST_FRC1;
            end
            default: state_nxt = ST_OUT;
          endcase
        end
      end
      ST_THR: begin
        mul_a = thr_sel;  mul_b = thr_sel;  thr_nxt = mul_p;  state_nxt = ST_SQ0;
      end
      ST_SQ0: begin
        mul_a = abs32(vel_x_r);  mul_b = mul_a;  sq_nxt = mul_p;  state_nxt = ST_SQ1;
      end
      ST_SQ1: begin
        mul_a = abs32(vel_y_r);  mul_b = mul_a;  sq_nxt = sq_r + mul_p;  state_nxt = ST_CHK;
      end
      ST_CHK: begin
        unique case (chk_r)
          CHK_FRIC: begin
            if (sq_r > thr_r) begin
              ctx_nxt = CTX_FRIC;  sqrt_go = 1'b1;
            end else begin
              vel_x_nxt = 32'd0;  vel_y_nxt = 32'd0;  state_nxt = ST_MOVE;
            end
          end
          CHK_LIM: begin
            if (sq_r > thr_r) begin
              ctx_nxt = CTX_LIM;  sqrt_go = 1'b1;
            end else begin
              chk_nxt = CHK_SLOW;  state_nxt = ST_THR;
            end
          end
          CHK_SLOW: begin
            if (sq_r < thr_r) begin
              vel_x_nxt = 32'd0;  vel_y_nxt = 32'd0;
            end
            state_nxt = (cmd_r == CMD_TICK) ? ST_MOVE : ST_OUT;
          end
          default: begin
            if (sq_r > thr_r) begin
              ctx_nxt = CTX_HEAD;  sqrt_go = 1'b1;
            end else begin
              state_nxt = ST_OUT;
            end
          end
        endcase
      end
      ST_SQRT: begin
        if (bit_r == 64'd0) begin
          div_go = 1'b1;  div_dvd = {2'd0, abs32(vel_x_r), 14'd0};
          div_dvs = rt_r[31:0];  div_neg = vel_x_r[31];  div_ret = ST_UNY;
        end else begin
          if (s_r >= rt_bit) begin
            s_nxt  = s_r - rt_bit;
            rt_nxt = (rt_r >> 1) + bit_r;
          end else begin
            rt_nxt = rt_r >> 1;
          end
          bit_nxt = bit_r >> 2;
        end
      end
      ST_UNY: begin
        ux_nxt = q_cur[15:0];
        div_go = 1'b1;  div_dvd = {2'd0, abs32(vel_y_r), 14'd0};
        div_dvs = rt_r[31:0];  div_neg = vel_y_r[31];  div_ret = ST_UEND;
      end
      ST_UEND: begin
        uy_nxt = q_cur[15:0];
        unique case (ctx_r)
          CTX_FRIC: state_nxt = ST_FMX;
          CTX_LIM:  state_nxt = ST_LMX;
          default: begin
            dir_x_nxt = ux_r;  dir_y_nxt = q_cur[15:0];  state_nxt = ST_OUT;
          end
        endcase
      end
      ST_FMX: begin
        mul_a = {16'd0, abs16(ux_r)};  mul_b = {1'b0, fric_r};
        prod_nxt = mul_p;  psgn_nxt = ~ux_r[15];  state_nxt = ST_FSX;
      end
      ST_FSX: begin
        div_go = 1'b1;  div_dvd = {prod_r[45:0], 2'd0};
        div_dvs = mass1;  div_neg = psgn_r;  div_ret = ST_FMY;
      end
      ST_FMY: begin
        dx_nxt = q_cur;
        mul_a = {16'd0, abs16(uy_r)};  mul_b = {1'b0, fric_r};
        prod_nxt = mul_p;  psgn_nxt = ~uy_r[15];  state_nxt = ST_FSY;
      end
      ST_FSY: begin
        div_go = 1'b1;  div_dvd = {prod_r[45:0], 2'd0};
        div_dvs = mass1;  div_neg = psgn_r;  div_ret = ST_FEND;
      end
      ST_FRC1: begin
        dx_nxt = q_cur;
        div_go = 1'b1;  div_dvd = {abs32(vin_y_r), 16'd0};
        div_dvs = mass1;  div_neg = vin_y_r[31];  div_ret = ST_FEND;
      end
      ST_FEND: begin
        // dy goes straight into the saturating add
        vel_x_nxt = sat_add(vel_x_r, dx_r);
        vel_y_nxt = sat_add(vel_y_r, q_cur);
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        chk_nxt = CHK_LIM;  state_nxt = ST_THR;
      end
      ST_LMX: begin
        mul_a = {16'd0, abs16(ux_r)};  mul_b = {1'b0, ms_r};
        prod_nxt = mul_p;  psgn_nxt = ux_r[15];  state_nxt = ST_LSX;
      end
      ST_LSX: begin
        vel_x_nxt = psgn_r ? (~lim_m + 32'd1) : lim_m;
        mul_a = {16'd0, abs16(uy_r)};  mul_b = {1'b0, ms_r};
        prod_nxt = mul_p;  psgn_nxt = uy_r[15];  state_nxt = ST_LSY;
      end
      ST_LSY: begin
        vel_y_nxt = psgn_r ? (~lim_m + 32'd1) : lim_m;
        chk_nxt = CHK_SLOW;  state_nxt = ST_THR;
      end
      ST_MOVE: begin
        pos_x_nxt = pos_x_r + vel_x_r;  pos_y_nxt = pos_y_r + vel_y_r;
        chk_nxt = CHK_HEAD;  state_nxt = ST_THR;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load = 1'b1;  out_valid_nxt = 1'b1;  state_nxt = ST_IDLE;
        end
      end
      default: begin
        // ST_DIV: one restoring step per cycle, quotient shifts into dvd_r
        rem_nxt = rem_ge ? 32'(rem_sh - {1'b0, dvs_r}) : rem_sh[31:0];
        dvd_nxt = {dvd_r[46:0], rem_ge};
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'(DIV_STEPS - 1)) state_nxt = dret_r;
      end
    endcase

    if (div_go) begin
      dvd_nxt = div_dvd;  dvs_nxt = div_dvs;  dneg_nxt = div_neg;  dret_nxt = div_ret;
      rem_nxt = 32'd0;  cnt_nxt = 6'd0;  state_nxt = ST_DIV;
    end
    if (sqrt_go) begin
      s_nxt = sq_r;  rt_nxt = 64'd0;  bit_nxt = 64'h4000_0000_0000_0000;
      state_nxt = ST_SQRT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;  chk_r <= CHK_FRIC;  ctx_r <= CTX_FRIC;  dret_r <= ST_IDLE;
      vel_x_r <= 32'd0;  vel_y_r <= 32'd0;  pos_x_r <= 32'd0;  pos_y_r <= 32'd0;
      dir_x_r <= 16'sd0;  dir_y_r <= 16'sd0;
      ms_r <= MAX_SPEED_RST;  mass_r <= BODY_MASS_RST;  fric_r <= FRICTION_RST;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;  chk_r <= chk_nxt;  ctx_r <= ctx_nxt;  dret_r <= dret_nxt;
      vel_x_r <= vel_x_nxt;  vel_y_r <= vel_y_nxt;  pos_x_r <= pos_x_nxt;  pos_y_r <= pos_y_nxt;
      dir_x_r <= dir_x_nxt;  dir_y_r <= dir_y_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid) begin
        unique case (cfg_ch.index)
          REG_MAX_SPEED: ms_r   <= cfg_ch.data;
          REG_BODY_MASS: mass_r <= cfg_ch.data;
          REG_FRICTION:  fric_r <= cfg_ch.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;  vin_y_r <= vin_y_nxt;  ux_r <= ux_nxt;  uy_r <= uy_nxt;
    dx_r <= dx_nxt;  sq_r <= sq_nxt;  thr_r <= thr_nxt;
    s_r <= s_nxt;  rt_r <= rt_nxt;  bit_r <= bit_nxt;  prod_r <= prod_nxt;  psgn_r <= psgn_nxt;
    dvd_r <= dvd_nxt;  dvs_r <= dvs_nxt;  rem_r <= rem_nxt;  cnt_r <= cnt_nxt;  dneg_r <= dneg_nxt;
    if (out_load) begin
      o_px_r <= pos_x_r;  o_py_r <= pos_y_r;  o_vx_r <= vel_x_r;  o_vy_r <= vel_y_r;
      o_hx_r <= dir_x_r;  o_hy_r <= dir_y_r;
    end
  end

  // a command in flight blocks the next one
  a_busy_after_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input taken while a command is in flight");

  // divider never runs on a zero divisor
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (dvs_r != 32'd0))
    else $error("divide by zero");

  // heading stays a unit vector component
  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    (dir_x_r <= 16'sd16384) && (dir_x_r >= -16'sd16384) &&
    (dir_y_r <= 16'sd16384) && (dir_y_r >= -16'sd16384))
    else $error("heading out of range");

endmodule
`default_nettype wire
